// ===== sv/ort_pkg.sv =====
package ort_pkg;

    typedef enum logic [2:0] {
        ST_MATCHED   = 3'd0,
        ST_OUT_ORDER = 3'd1,
        ST_UNKNOWN_Q = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_UNSUPP    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POST,
        S_RDQ,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_OUT
    } t_state;

    localparam int unsigned EntryW = 32 + 48 + 32 + 48 + 48 + 48;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic post;
        logic rd_entry;
        logic pop;
        logic match;
        logic set_status;
        t_status status;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic unsupp;
        logic q_bad;
        logic is_done;
        logic seen;
        logic empty;
        logic id_lt;
        logic id_eq;
    } t_sts;

endpackage

// ===== sv/outstanding_request_tracker_top.sv =====
// A post goes through the states RDQ and POST before the next word can be taken.
// A completion goes through RDQ, then READ, WAIT and CHECK for each head entry examined,
// then OUT; it goes from READ to OUT when the FIFO runs empty. A rejected or unknown-queue
// event goes from RDQ straight to OUT. One event at a time: a new word is taken only in
// IDLE, after a post is written or after the result in OUT is accepted.
// Reset (synchronous, active low) clears per-queue counters, times and seen flags;
// the entry RAM is not cleared and only slots written by a post are read.
module outstanding_request_tracker_top import ort_pkg::*; #(
    parameter int unsigned NUM_QUEUES = 16,
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic        i_is_send,
    input  logic [3:0]  i_queue_pair,
    input  logic [31:0] i_request_id,
    input  logic [47:0] i_timestamp_us,
    input  logic [31:0] i_total_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_request_id_res,
    output logic [3:0]  o_queue_pair_res,
    output logic [47:0] o_post_time_us,
    output logic [47:0] o_gap_from_prev_post_us,
    output logic [47:0] o_gap_from_prev_done_us,
    output logic [31:0] o_request_bytes,
    output logic [47:0] o_inflight_on_post,
    output logic [47:0] o_inflight_on_done
);
    t_cmd w_cmd;
    t_sts w_sts;

    ort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ort_dp #(.NUM_QUEUES(NUM_QUEUES), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_sts                   (w_sts),
        .i_command               (i_command),
        .i_is_send               (i_is_send),
        .i_queue_pair            (i_queue_pair),
        .i_request_id            (i_request_id),
        .i_timestamp_us          (i_timestamp_us),
        .i_total_bytes           (i_total_bytes),
        .o_status                (o_status),
        .o_request_id_res        (o_request_id_res),
        .o_queue_pair_res        (o_queue_pair_res),
        .o_post_time_us          (o_post_time_us),
        .o_gap_from_prev_post_us (o_gap_from_prev_post_us),
        .o_gap_from_prev_done_us (o_gap_from_prev_done_us),
        .o_request_bytes         (o_request_bytes),
        .o_inflight_on_post      (o_inflight_on_post),
        .o_inflight_on_done      (o_inflight_on_done)
    );
endmodule

// ===== sv/ort_ram.sv =====
module ort_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ort_ctrl.sv =====
module ort_ctrl import ort_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.status = ST_MATCHED;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RDQ;
                end
            end
            S_RDQ: begin
                o_cmd.set_status = 1'b1;
                if (i_sts.unsupp) begin
                    o_cmd.status = ST_UNSUPP;
                    n_state      = S_OUT;
                end else if (i_sts.q_bad) begin
                    o_cmd.status = ST_UNKNOWN_Q;
                    n_state      = S_OUT;
                end else if (!i_sts.is_done) begin
                    o_cmd.set_status = 1'b0;
                    n_state          = S_POST;
                end else if (!i_sts.seen) begin
                    o_cmd.status = ST_UNKNOWN_Q;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.set_status = 1'b0;
                    n_state          = S_READ;
                end
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = S_IDLE;
            end
            S_READ: begin
                if (i_sts.empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.rd_entry = 1'b1;
                    n_state        = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.id_lt) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_READ;
                end else if (i_sts.id_eq) begin
                    o_cmd.pop   = 1'b1;
                    o_cmd.match = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OUT_ORDER;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/ort_dp.sv =====
module ort_dp import ort_pkg::*; #(
    parameter int unsigned NUM_QUEUES = 16,
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_command,
    input  logic        i_is_send,
    input  logic [3:0]  i_queue_pair,
    input  logic [31:0] i_request_id,
    input  logic [47:0] i_timestamp_us,
    input  logic [31:0] i_total_bytes,
    output logic [2:0]  o_status,
    output logic [31:0] o_request_id_res,
    output logic [3:0]  o_queue_pair_res,
    output logic [47:0] o_post_time_us,
    output logic [47:0] o_gap_from_prev_post_us,
    output logic [47:0] o_gap_from_prev_done_us,
    output logic [31:0] o_request_bytes,
    output logic [47:0] o_inflight_on_post,
    output logic [47:0] o_inflight_on_done
);
    localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned SW  = QW + PW;
    localparam int unsigned NQS = 1 << QW;
    localparam logic [47:0] MAX48 = '1;

    logic              r_seen    [NUM_QUEUES];
    logic [47:0]       r_lpost   [NUM_QUEUES];
    logic [47:0]       r_ldone   [NUM_QUEUES];
    logic [47:0]       r_bif     [NUM_QUEUES];
    logic [PW-1:0]     r_head    [NUM_QUEUES];
    logic [CW-1:0]     r_count   [NUM_QUEUES];

    logic              r_cmd, r_snd;
    logic [3:0]        r_qin;
    logic [31:0]       r_id, r_tb;
    logic [47:0]       r_ts;
    logic [QW-1:0]     r_q;
    logic              r_qbad;

    // per-queue state snapshot for the current event
    logic [47:0]       r_c_lpost, r_c_ldone, r_c_bif;
    logic [PW-1:0]     r_c_head;
    logic [CW-1:0]     r_c_count;

    logic [2:0]        r_status;
    logic [31:0]       r_o_id, r_o_bytes;
    logic [47:0]       r_o_pt, r_o_pg, r_o_dg, r_o_ip, r_o_id2;

    logic [EntryW-1:0] w_wdata, w_rdata;
    logic [SW-1:0]     w_waddr, w_raddr;
    logic              w_we;

    logic [31:0]       e_id, e_bytes;
    logic [47:0]       e_pt, e_ip, e_pg, e_dg;
    assign {e_id, e_pt, e_bytes, e_ip, e_pg, e_dg} = w_rdata;

    // post path
    logic              p_full;
    logic [PW-1:0]     p_head;
    logic [CW-1:0]     p_count;
    logic [CW:0]       p_wsum;
    logic [PW-1:0]     p_slot;
    logic [47:0]       p_pg, p_dg, p_bif;
    logic [48:0]       p_sum;
    logic [47:0]       d_bif;

    always_comb begin
        p_full  = (r_c_count >= CW'(FIFO_DEPTH));
        p_head  = r_c_head;
        p_count = r_c_count;
        if (p_full) begin
            p_head  = (r_c_head == PW'(FIFO_DEPTH - 1)) ? '0 : r_c_head + 1'b1;
            p_count = r_c_count - 1'b1;
        end
        // wrap head + count back into the ring
        p_wsum = (CW+1)'(p_head) + (CW+1)'(p_count);
        p_slot = (p_wsum >= (CW+1)'(FIFO_DEPTH)) ? PW'(p_wsum - (CW+1)'(FIFO_DEPTH))
                                                 : PW'(p_wsum);
        p_pg = (r_c_lpost != 0 && r_ts >= r_c_lpost) ? r_ts - r_c_lpost : '0;
        p_dg = (r_c_bif == 0 && r_c_ldone != 0 && r_ts >= r_c_ldone)
               ? r_ts - r_c_ldone : '0;
        p_sum = {1'b0, r_c_bif} + 49'(r_tb);
        p_bif = p_sum[48] ? MAX48 : p_sum[47:0];
        d_bif = (r_c_bif >= 48'(e_bytes)) ? r_c_bif - 48'(e_bytes) : '0;
    end

    assign w_we    = i_cmd.post;
    assign w_waddr = {r_q, p_slot};
    assign w_wdata = {r_id, r_ts, r_tb, r_c_bif, p_pg, p_dg};
    assign w_raddr = {r_q, r_c_head};

    ort_ram #(.WIDTH(EntryW), .DEPTH(NQS * (1 << PW))) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_snd  <= i_is_send;
            r_qin  <= i_queue_pair;
            r_id   <= i_request_id;
            r_ts   <= i_timestamp_us;
            r_tb   <= i_total_bytes;
            r_q    <= QW'(i_queue_pair);
            r_qbad <= (32'(i_queue_pair) >= NUM_QUEUES);
            r_status <= ST_MATCHED;
            r_o_id <= '0; r_o_bytes <= '0; r_o_pt <= '0; r_o_pg <= '0;
            r_o_dg <= '0; r_o_ip <= '0; r_o_id2 <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.match) begin
            r_o_id    <= e_id;
            r_o_pt    <= e_pt;
            r_o_pg    <= e_pg;
            r_o_dg    <= e_dg;
            r_o_bytes <= e_bytes;
            r_o_ip    <= e_ip;
            r_o_id2   <= d_bif;
        end
    end

    // snapshot register: follows the table for the selected queue
    logic r_snap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= 1'b0;
        end else begin
            r_snap <= i_cmd.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_snap && !r_qbad) begin
            r_c_lpost <= r_lpost[r_q];
            r_c_ldone <= r_ldone[r_q];
            r_c_bif   <= r_bif[r_q];
            r_c_head  <= r_head[r_q];
            r_c_count <= r_count[r_q];
        end else if (i_cmd.pop) begin
            r_c_bif   <= d_bif;
            r_c_ldone <= r_ts;
            r_c_head  <= (r_c_head == PW'(FIFO_DEPTH - 1)) ? '0 : r_c_head + 1'b1;
            r_c_count <= r_c_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_seen[i]  <= 1'b0;
                r_lpost[i] <= '0;
                r_ldone[i] <= '0;
                r_bif[i]   <= '0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_cmd.post) begin
            r_seen[r_q]  <= 1'b1;
            r_lpost[r_q] <= r_ts;
            r_bif[r_q]   <= p_bif;
            r_head[r_q]  <= p_head;
            r_count[r_q] <= p_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_bif[r_q]   <= d_bif;
            r_ldone[r_q] <= r_ts;
            r_head[r_q]  <= (r_c_head == PW'(FIFO_DEPTH - 1)) ? '0 : r_c_head + 1'b1;
            r_count[r_q] <= r_c_count - 1'b1;
        end
    end

    always_comb begin
        o_sts.unsupp  = !r_snd;
        o_sts.q_bad   = r_qbad;
        o_sts.is_done = r_cmd;
        // read straight from the table: the snapshot is not loaded yet when this is checked
        o_sts.seen    = r_seen[r_q];
        o_sts.empty   = (r_c_count == 0);
        o_sts.id_lt   = (e_id < r_id);
        o_sts.id_eq   = (e_id == r_id);
    end

    assign o_status                = r_status;
    assign o_request_id_res        = r_o_id;
    assign o_queue_pair_res        = r_qin;
    assign o_post_time_us          = r_o_pt;
    assign o_gap_from_prev_post_us = r_o_pg;
    assign o_gap_from_prev_done_us = r_o_dg;
    assign o_request_bytes         = r_o_bytes;
    assign o_inflight_on_post      = r_o_ip;
    assign o_inflight_on_done      = r_o_id2;
endmodule

// ===== sim/outstanding_request_tracker_top_test.sv =====
`timescale 1ns / 1ps

module outstanding_request_tracker_top_test import ort_pkg::*;;

    localparam int NQ = 16;
    localparam int DEPTH = 64;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic        command;
        logic        is_send;
        logic [3:0]  queue_pair;
        logic [31:0] request_id;
        logic [47:0] timestamp_us;
        logic [31:0] total_bytes;
    } t_event;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] request_id;
        logic [3:0]  queue_pair;
        logic [47:0] post_time;
        logic [47:0] post_gap;
        logic [47:0] done_gap;
        logic [31:0] req_bytes;
        logic [47:0] inflight_post;
        logic [47:0] inflight_done;
    } t_report;

    typedef struct packed {
        logic [31:0] id;
        logic [47:0] post_time;
        logic [31:0] req_bytes;
        logic [47:0] inflight;
        logic [47:0] post_gap;
        logic [47:0] done_gap;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic        i_is_send = 1'b0;
    logic [3:0]  i_queue_pair = '0;
    logic [31:0] i_request_id = '0;
    logic [47:0] i_timestamp_us = '0;
    logic [31:0] i_total_bytes = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_request_id_res;
    logic [3:0]  o_queue_pair_res;
    logic [47:0] o_post_time_us;
    logic [47:0] o_gap_from_prev_post_us;
    logic [47:0] o_gap_from_prev_done_us;
    logic [31:0] o_request_bytes;
    logic [47:0] o_inflight_on_post;
    logic [47:0] o_inflight_on_done;

    outstanding_request_tracker_top uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // tracker state mirror
    logic        seen_q [NQ];
    logic [47:0] last_post [NQ];
    logic [47:0] last_done [NQ];
    logic [47:0] inflight_q [NQ];
    t_entry      pending_q [NQ][$];

    t_event  event_queue[$];
    t_report expected_reports[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_off = 0;
    logic    drain_pause = 1'b0;

    function automatic logic [47:0] gap_of(logic [47:0] now, logic [47:0] then);
        return (now >= then) ? now - then : 48'd0;
    endfunction

    function automatic void track_event(t_event ev);
        t_report r;
        t_entry  e;
        int      q;
        r = '0;
        r.queue_pair = ev.queue_pair;
        q = ev.queue_pair;
        if (!ev.is_send) begin
            r.status = ST_UNSUPP;
            expected_reports.insert(expected_reports.size(), r);
            return;
        end
        if (ev.command == 1'b0) begin
            if (pending_q[q].size() >= DEPTH) pending_q[q].delete(0);
            e.id = ev.request_id;
            e.post_time = ev.timestamp_us;
            e.req_bytes = ev.total_bytes;
            e.inflight = inflight_q[q];
            e.post_gap = (last_post[q] != 0) ? gap_of(ev.timestamp_us, last_post[q]) : 48'd0;
            e.done_gap = (inflight_q[q] == 0 && last_done[q] != 0) ?
                         gap_of(ev.timestamp_us, last_done[q]) : 48'd0;
            pending_q[q].insert(pending_q[q].size(), e);
            inflight_q[q] = (MAX48 - inflight_q[q] >= {16'd0, ev.total_bytes}) ?
                            inflight_q[q] + ev.total_bytes : MAX48;
            last_post[q] = ev.timestamp_us;
            seen_q[q] = 1'b1;
            return;
        end
        if (!seen_q[q]) begin
            r.status = ST_UNKNOWN_Q;
            expected_reports.insert(expected_reports.size(), r);
            return;
        end
        r.status = ST_NOT_FOUND;
        while (pending_q[q].size() > 0) begin
            e = pending_q[q][0];
            if (e.id > ev.request_id) begin
                r.status = ST_OUT_ORDER;
                break;
            end
            inflight_q[q] = (inflight_q[q] >= {16'd0, e.req_bytes}) ?
                            inflight_q[q] - e.req_bytes : 48'd0;
            last_done[q] = ev.timestamp_us;
            pending_q[q].delete(0);
            if (e.id == ev.request_id) begin
                r.status = ST_MATCHED;
                r.request_id = e.id;
                r.post_time = e.post_time;
                r.post_gap = e.post_gap;
                r.done_gap = e.done_gap;
                r.req_bytes = e.req_bytes;
                r.inflight_post = e.inflight;
                r.inflight_done = inflight_q[q];
                break;
            end
        end
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic t_event make_event(logic cmd, logic snd, logic [3:0] q,
                                          logic [31:0] id, logic [47:0] ts, logic [31:0] tb);
        t_event ev;
        ev.command = cmd;
        ev.is_send = snd;
        ev.queue_pair = q;
        ev.request_id = id;
        ev.timestamp_us = ts;
        ev.total_bytes = tb;
        return ev;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (event_queue.size() > 0 && !drain_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    t_event ev;
                    ev = event_queue[0];
                    event_queue.delete(0);
                    track_event(ev);
                    i_in_valid <= 1'b1;
                    i_command <= ev.command;
                    i_is_send <= ev.is_send;
                    i_queue_pair <= ev.queue_pair;
                    i_request_id <= ev.request_id;
                    i_timestamp_us <= ev.timestamp_us;
                    i_total_bytes <= ev.total_bytes;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_report got;
            t_report want;
            got = {o_status, o_request_id_res, o_queue_pair_res, o_post_time_us,
                   o_gap_from_prev_post_us, o_gap_from_prev_done_us, o_request_bytes,
                   o_inflight_on_post, o_inflight_on_done};
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors = errors + 1;
            end else begin
                want = expected_reports[0];
                expected_reports.delete(0);
                if (got.status !== want.status)
                    $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
                if (got.request_id !== want.request_id)
                    $display("%0t: id exp %h act %h", $time, want.request_id, got.request_id);
                if (got.queue_pair !== want.queue_pair)
                    $display("%0t: qp exp %0d act %0d", $time, want.queue_pair, got.queue_pair);
                if (got.post_time !== want.post_time)
                    $display("%0t: post_time exp %h act %h", $time, want.post_time, got.post_time);
                if (got.post_gap !== want.post_gap)
                    $display("%0t: post_gap exp %h act %h", $time, want.post_gap, got.post_gap);
                if (got.done_gap !== want.done_gap)
                    $display("%0t: done_gap exp %h act %h", $time, want.done_gap, got.done_gap);
                if (got.req_bytes !== want.req_bytes)
                    $display("%0t: bytes exp %h act %h", $time, want.req_bytes, got.req_bytes);
                if (got.inflight_post !== want.inflight_post)
                    $display("%0t: inflight_post exp %h act %h", $time, want.inflight_post,
                             got.inflight_post);
                if (got.inflight_done !== want.inflight_done)
                    $display("%0t: inflight_done exp %h act %h", $time, want.inflight_done,
                             got.inflight_done);
                if (got !== want) errors = errors + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("** outstanding_request_tracker_top: FAILED **");
            $finish;
        end
    end

    logic [31:0] next_id [NQ];
    logic [47:0] clock_us [NQ];

    task automatic add_random(int n);
        t_event       ev;
        logic [127:0] noise;
        int           q;
        int           k;
        for (int i = 0; i < n; i++) begin
            q = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(3);
            k = $urandom_range(99);
            clock_us[q] = clock_us[q] + $urandom_range(50) - ($urandom_range(15) == 0 ? 60 : 0);
            if (k < 5) begin
                // noise: random fields, any operation
                noise = {$urandom, $urandom, $urandom, $urandom};
                ev = noise[$bits(t_event)-1:0];
                event_queue.insert(event_queue.size(), ev);
            end else if (k < 55) begin
                next_id[q] = next_id[q] + $urandom_range(1, 3);
                event_queue.insert(event_queue.size(),
                    make_event(1'b0, 1'b1, 4'(q), next_id[q], clock_us[q],
                    $urandom_range(7) == 0 ? $urandom : $urandom_range(4096)));
            end else begin
                event_queue.insert(event_queue.size(), make_event(1'b1, 1'b1, 4'(q),
                    next_id[q] - $urandom_range(6), clock_us[q], $urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (event_queue.size() > 0 || i_in_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic add_event(t_event ev);
        event_queue.insert(event_queue.size(), ev);
    endtask

    initial begin
        for (int q = 0; q < NQ; q++) begin
            seen_q[q] = 1'b0;
            last_post[q] = '0;
            last_done[q] = '0;
            inflight_q[q] = '0;
            next_id[q] = 32'd100;
            clock_us[q] = 48'd1000;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unsupported, unknown queue, extremes, saturation, out of order
        add_event(make_event(1'b0, 1'b0, 4'd3, 32'd5, 48'd10, 32'd1));
        add_event(make_event(1'b1, 1'b0, 4'd15, '1, '1, '1));
        add_event(make_event(1'b1, 1'b1, 4'd9, 32'd1, 48'd5, 32'd0));
        add_event(make_event(1'b0, 1'b1, 4'd15, 32'd0, 48'd0, '1));
        add_event(make_event(1'b0, 1'b1, 4'd15, 32'd1, MAX48, '1));
        add_event(make_event(1'b0, 1'b1, 4'd15, 32'd7, 48'd3, 32'd5));
        add_event(make_event(1'b1, 1'b1, 4'd15, 32'd1, 48'd20, '0));
        add_event(make_event(1'b1, 1'b1, 4'd15, 32'd3, 48'd30, '0));
        add_event(make_event(1'b1, 1'b1, 4'd15, 32'd7, 48'd40, '0));
        add_event(make_event(1'b1, 1'b1, 4'd15, 32'd9, 48'd50, '0));
        add_event(make_event(1'b0, 1'b1, 4'd15, '1, 48'd60, 32'd8));
        add_event(make_event(1'b1, 1'b1, 4'd15, '1, 48'd45, '0));
        add_event(make_event(1'b0, 1'b1, 4'd15, 32'd2, 48'd70, 32'd8));
        // overflow one queue past full depth
        for (int i = 0; i < DEPTH + 3; i++)
            add_event(make_event(1'b0, 1'b1, 4'd0, 32'd10 + i, 48'd100 + i, 32'd9));
        add_event(make_event(1'b1, 1'b1, 4'd0, 32'd11, 48'd500, '0));
        add_event(make_event(1'b1, 1'b1, 4'd0, 32'd12, 48'd501, '0));
        wait_drained();

        send_idle_pct = 31;
        recv_idle_pct = 67;
        add_random(500);
        wait_drained();

        // long hold-off on the result side to back the block up
        hold_off = 400;
        add_random(60);
        wait_drained();

        send_idle_pct = 67;
        recv_idle_pct = 31;
        add_random(500);
        // pause until every expected result has come
        while (event_queue.size() > 250) @(posedge i_clk);
        drain_pause = 1'b1;
        while (i_in_valid || expected_reports.size() > 0) @(posedge i_clk);
        drain_pause = 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(540);
        wait_drained();

        if (errors == 0 && expected_reports.size() == 0)
            $display("** outstanding_request_tracker_top: PASSED **");
        else
            $display("** outstanding_request_tracker_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ort_pkg.sv
sv/ort_ram.sv
sv/ort_ctrl.sv
sv/ort_dp.sv
sv/outstanding_request_tracker_top.sv
sim/outstanding_request_tracker_top_test.sv
